### src/msp_pkg.sv
`timescale 1ns / 1ps

package msp_pkg;

    // Saturation point of the tick counter between encoder edges
    localparam logic [9:0] PERIOD_MAX     = 10'd1023;
    // Upper clamp of the heat counter
    localparam logic [9:0] HEAT_MAX       = 10'd1000;
    // Largest duty the accumulator may hold
    localparam logic [9:0] DUTY_MAX       = 10'd1023;
    // Setpoint code that stops the drive
    localparam logic [7:0] STOP_SETPOINT  = 8'd255;
    // Direction code that selects right rotation
    localparam logic [7:0] DIR_RIGHT_CODE = 8'd128;

    // Register reset values
    localparam logic [7:0] RST_SETPOINT  = 8'd255;
    localparam logic [7:0] RST_DIR_CODE  = 8'd255;
    localparam logic [3:0] RST_GAIN      = 4'd2;
    localparam logic [9:0] RST_SOFT_HEAT = 10'd50;
    localparam logic [9:0] RST_HARD_HEAT = 10'd400;
    localparam logic [9:0] RST_SOFT_DUTY = 10'd900;
    localparam logic [9:0] RST_HARD_DUTY = 10'd50;

    // APB address width: seven 32-bit registers at 4*i
    localparam int ADDR_W = 5;

    // Register index, taken from paddr[4:2]
    typedef enum logic [2:0] {
        REG_SETPOINT  = 3'd0,
        REG_DIR_CODE  = 3'd1,
        REG_GAIN      = 3'd2,
        REG_SOFT_HEAT = 3'd3,
        REG_HARD_HEAT = 3'd4,
        REG_SOFT_DUTY = 3'd5,
        REG_HARD_DUTY = 3'd6
    } t_reg_idx;

    // One tick sample
    typedef struct packed {
        logic encoder_level;
        logic overcurrent;
    } t_in_word;

    // One regulation update
    typedef struct packed {
        logic [9:0] duty;
        logic       dir_right;
        logic       current_warning;
        logic [9:0] measured_period;
    } t_out_word;

endpackage

### src/motor_speed_p_regulator.sv
`timescale 1ns / 1ps

// Motor speed P regulator. Each accepted input word is one tick: the encoder
// A level and the over-current comparator bit. A tick that sees an encoder
// level change, or that brings the tick counter to saturation, latches the
// measured period, runs one proportional duty update with heat limiting, and
// yields one output word; other ticks yield none. One word is accepted every
// clock while the output is not stalled; each result comes from its tick
// through the input register and the single update stage that loads the
// output register. A stalled output holds the update stage, and the input
// register with it once that is full, so at most one more tick is taken while
// a result waits. Registers must be written over APB only while the block is
// idle; the block itself does not enforce this. pready is always high.
module motor_speed_p_regulator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Tick input
    input  logic                          i_valid,
    output logic                          o_ready,
    input  msp_pkg::t_in_word             i_data,
    // Result output
    output logic                          o_valid,
    input  logic                          i_ready,
    output msp_pkg::t_out_word            o_data,
    // Configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [msp_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    // Configuration registers
    logic [7:0] r_setpoint;
    logic [7:0] r_dir_code;
    logic [3:0] r_gain;
    logic [9:0] r_soft_heat;
    logic [9:0] r_hard_heat;
    logic [9:0] r_soft_duty;
    logic [9:0] r_hard_duty;

    // Regulator state
    logic [9:0] r_period_cnt;
    logic       r_enc_prev;
    logic [9:0] r_duty;
    logic [9:0] r_heat;

    // Pipeline registers
    logic               r_in_valid;
    msp_pkg::t_in_word  r_in;
    logic               r_out_valid;
    msp_pkg::t_out_word r_out;

    // Update datapath
    logic               w_adv;
    logic               w_update;
    logic [9:0]         w_cnt_inc;
    logic signed [10:0] w_err;
    logic signed [15:0] w_prod;
    logic signed [17:0] w_sum;
    logic [9:0]         w_duty_clamp;
    logic signed [11:0] w_heat_step;
    logic [9:0]         w_duty_final;
    logic [9:0]         w_heat_final;
    logic               w_cfg_wr;
    msp_pkg::t_reg_idx  w_reg_idx;

    // APB decode
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite;
    assign w_reg_idx = msp_pkg::t_reg_idx'(paddr[msp_pkg::ADDR_W-1:2]);

    always_comb begin
        case (w_reg_idx)
            msp_pkg::REG_SETPOINT:  prdata = {24'd0, r_setpoint};
            msp_pkg::REG_DIR_CODE:  prdata = {24'd0, r_dir_code};
            msp_pkg::REG_GAIN:      prdata = {28'd0, r_gain};
            msp_pkg::REG_SOFT_HEAT: prdata = {22'd0, r_soft_heat};
            msp_pkg::REG_HARD_HEAT: prdata = {22'd0, r_hard_heat};
            msp_pkg::REG_SOFT_DUTY: prdata = {22'd0, r_soft_duty};
            msp_pkg::REG_HARD_DUTY: prdata = {22'd0, r_hard_duty};
            default:                prdata = 32'd0;
        endcase
    end

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint  <= msp_pkg::RST_SETPOINT;
            r_dir_code  <= msp_pkg::RST_DIR_CODE;
            r_gain      <= msp_pkg::RST_GAIN;
            r_soft_heat <= msp_pkg::RST_SOFT_HEAT;
            r_hard_heat <= msp_pkg::RST_HARD_HEAT;
            r_soft_duty <= msp_pkg::RST_SOFT_DUTY;
            r_hard_duty <= msp_pkg::RST_HARD_DUTY;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                msp_pkg::REG_SETPOINT:  r_setpoint  <= pwdata[7:0];
                msp_pkg::REG_DIR_CODE:  r_dir_code  <= pwdata[7:0];
                msp_pkg::REG_GAIN:      r_gain      <= pwdata[3:0];
                msp_pkg::REG_SOFT_HEAT: r_soft_heat <= pwdata[9:0];
                msp_pkg::REG_HARD_HEAT: r_hard_heat <= pwdata[9:0];
                msp_pkg::REG_SOFT_DUTY: r_soft_duty <= pwdata[9:0];
                msp_pkg::REG_HARD_DUTY: r_hard_duty <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    // Advance the update stage when the output slot is free or being taken
    assign w_adv   = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || w_adv;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // Count the tick, saturating
    assign w_cnt_inc = (r_period_cnt == msp_pkg::PERIOD_MAX) ? msp_pkg::PERIOD_MAX
                                                              : r_period_cnt + 10'd1;
    assign w_update  = (r_in.encoder_level != r_enc_prev) ||
                       (w_cnt_inc == msp_pkg::PERIOD_MAX);

    // Proportional step on the period error
    assign w_err  = $signed({1'b0, w_cnt_inc}) - $signed({3'b000, r_setpoint});
    assign w_prod = 16'($signed({1'b0, r_gain})) * 16'(w_err);
    assign w_sum  = $signed({8'd0, r_duty}) + 18'(w_prod);

    always_comb begin
        if (r_setpoint == msp_pkg::STOP_SETPOINT || w_sum < 18'sd0) begin
            w_duty_clamp = 10'd0;
        end else if (w_sum > $signed({8'd0, msp_pkg::DUTY_MAX})) begin
            w_duty_clamp = msp_pkg::DUTY_MAX;
        end else begin
            w_duty_clamp = w_sum[9:0];
        end
    end

    // Step heat, force limit duty, clamp heat
    assign w_heat_step = r_in.overcurrent ? $signed({2'b00, r_heat}) + 12'sd1
                                          : $signed({2'b00, r_heat}) - 12'sd1;

    always_comb begin
        w_duty_final = w_duty_clamp;
        if (w_heat_step > $signed({2'b00, r_soft_heat})) begin
            w_duty_final = r_soft_duty;
        end
        if (w_heat_step > $signed({2'b00, r_hard_heat})) begin
            w_duty_final = r_hard_duty;
        end
        if (w_heat_step < 12'sd1) begin
            w_heat_final = 10'd1;
        end else if (w_heat_step > $signed({2'b00, msp_pkg::HEAT_MAX})) begin
            w_heat_final = msp_pkg::HEAT_MAX;
        end else begin
            w_heat_final = w_heat_step[9:0];
        end
    end

    // Input register: hold a word until the update stage takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in <= i_data;
        end
    end

    // Regulator state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period_cnt <= 10'd0;
            r_enc_prev   <= 1'b0;
            r_duty       <= 10'd0;
            r_heat       <= 10'd0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_adv) begin
                if (w_update) begin
                    r_period_cnt <= 10'd0;
                    r_enc_prev   <= r_in.encoder_level;
                    r_duty       <= w_duty_final;
                    r_heat       <= w_heat_final;
                end else begin
                    r_period_cnt <= w_cnt_inc;
                end
            end
            if (w_adv) begin
                r_out_valid <= w_update;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (w_adv && w_update) begin
            r_out.duty            <= w_duty_final;
            r_out.dir_right       <= (r_dir_code == msp_pkg::DIR_RIGHT_CODE);
            r_out.current_warning <= r_in.overcurrent;
            r_out.measured_period <= w_cnt_inc;
        end
    end

    // Heat never exceeds its upper clamp
    a_heat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_heat <= msp_pkg::HEAT_MAX)
        else $error("heat counter above its maximum");

    // A new result needs a word in the update stage the cycle before
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_in_valid))
        else $error("result appeared without an input word");

    // An update clears the tick counter
    a_cnt_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_update) |=> (r_period_cnt == 10'd0))
        else $error("tick counter not cleared after update");

    // A stalled stage leaves regulator state alone
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !i_ready) |=> ($stable(r_duty) && $stable(r_heat)))
        else $error("state changed while output stalled");

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    // Address slot past the last register, must be ignored on write
    localparam logic [2:0] REG_UNUSED = 3'd7;
    // Cycles to let an in-flight tick drain before a register write
    localparam int DRAIN_CYCLES = 8;
    // Random part length in ticks
    localparam int RANDOM_TICKS = 400;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_ready;
    msp_pkg::t_in_word             i_data;
    logic                          o_valid;
    logic                          i_ready;
    msp_pkg::t_out_word            o_data;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [msp_pkg::ADDR_W-1:0]    paddr;
    logic [31:0]                   pwdata;
    logic [31:0]                   prdata;
    logic                          pready;

    // Regulator state as the testbench predicts it
    int                    tick_count;
    logic                  last_level;
    int                    duty_acc;
    int                    heat;
    logic [7:0]            cfg_setpoint;
    logic [7:0]            cfg_dir_code;
    logic [3:0]            cfg_gain;
    logic [9:0]            cfg_soft_heat;
    logic [9:0]            cfg_hard_heat;
    logic [9:0]            cfg_soft_duty;
    logic [9:0]            cfg_hard_duty;

    msp_pkg::t_out_word    pending_updates[$];
    msp_pkg::t_out_word    want_upd;
    int                    fail_count;
    int                    ticks_sent;
    logic                  enc_level;
    bit                    allow_gaps;
    int                    stall_request;

    motor_speed_p_regulator i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #2 i_clk = ~i_clk;

    // Advance the predicted regulator by one tick; return 1 when it yields an update
    function automatic bit step_regulator(input msp_pkg::t_in_word w,
                                          output msp_pkg::t_out_word upd);
        int period;
        upd = '0;
        tick_count = tick_count + 1;
        if (tick_count >= int'(msp_pkg::PERIOD_MAX)) tick_count = int'(msp_pkg::PERIOD_MAX);
        if (w.encoder_level == last_level && tick_count != int'(msp_pkg::PERIOD_MAX)) begin
            return 1'b0;
        end
        period     = tick_count;
        tick_count = 0;
        last_level = w.encoder_level;

        // Proportional step, stop code, clamp
        duty_acc = duty_acc + int'(cfg_gain) * (period - int'(cfg_setpoint));
        if (cfg_setpoint == msp_pkg::STOP_SETPOINT) duty_acc = 0;
        if (duty_acc < 0) duty_acc = 0;
        if (duty_acc > int'(msp_pkg::DUTY_MAX)) duty_acc = int'(msp_pkg::DUTY_MAX);

        // Heat walk: thresholds see the unclamped value, hard wins over soft
        heat = w.overcurrent ? heat + 1 : heat - 1;
        if (heat > int'(cfg_soft_heat)) duty_acc = int'(cfg_soft_duty);
        if (heat > int'(cfg_hard_heat)) duty_acc = int'(cfg_hard_duty);
        if (heat < 1) heat = 1;
        if (heat > int'(msp_pkg::HEAT_MAX)) heat = int'(msp_pkg::HEAT_MAX);

        upd.duty            = duty_acc[9:0];
        upd.dir_right       = (cfg_dir_code == msp_pkg::DIR_RIGHT_CODE);
        upd.current_warning = w.overcurrent;
        upd.measured_period = (period > 1023) ? 10'd1023 : period[9:0];
        return 1'b1;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            fail_count++;
        end
    endfunction

    // Compare each accepted output word with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_updates.size() == 0) begin
                $display("%0t: unexpected output word, expected none, got %h", $time, o_data);
                fail_count++;
            end else begin
                want_upd = pending_updates.pop_front();
                check_field("duty", want_upd.duty, o_data.duty);
                check_field("dir_right", want_upd.dir_right, o_data.dir_right);
                check_field("current_warning", want_upd.current_warning,
                            o_data.current_warning);
                check_field("measured_period", want_upd.measured_period,
                            o_data.measured_period);
            end
        end
    end

    // Drive the output ready: random stalls, long hold-offs on request
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        i_ready   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_request > 0) begin
                hold_left     = stall_request;
                stall_request = 0;
            end
            if (hold_left > 0) begin
                i_ready <= 1'b0;
                hold_left--;
            end else if (!allow_gaps) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= 18);
            end
        end
    end

    // Drop valid at random between ticks, scrambling the idle payload
    task automatic sender_gap();
        int n;
        if (allow_gaps && $urandom_range(0, 99) < 18) begin
            n = $urandom_range(1, 2);
            repeat (n) begin
                @(negedge i_clk);
                i_valid <= 1'b0;
                i_data.encoder_level <= 1'($urandom_range(0, 1));
                i_data.overcurrent   <= 1'($urandom_range(0, 1));
            end
        end
    endtask

    // Offer one tick word and hold it until accepted
    task automatic send_tick(logic level, logic oc);
        msp_pkg::t_in_word  w;
        msp_pkg::t_out_word upd;
        w.encoder_level = level;
        w.overcurrent   = oc;
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_data  <= w;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (step_regulator(w, upd)) pending_updates.push_back(upd);
        ticks_sent++;
        sender_gap();
    endtask

    // Hold the encoder level for len-1 ticks, toggle it on the last
    task automatic send_run(int len, int oc_pct);
        for (int i = 0; i < len; i++) begin
            if (i == len - 1) enc_level = ~enc_level;
            send_tick(enc_level, $urandom_range(0, 99) < oc_pct);
        end
    endtask

    // Idle the input until every prediction has been met, then let the pipe drain
    task automatic wait_results_done();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_updates.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // One APB write: setup then access; unused data bits carry random junk
    task automatic write_reg(logic [2:0] idx, int value);
        logic [31:0] wdata;
        wdata = $urandom();
        case (idx)
            msp_pkg::REG_SETPOINT: begin
                wdata[7:0]   = value[7:0];
                cfg_setpoint = value[7:0];
            end
            msp_pkg::REG_DIR_CODE: begin
                wdata[7:0]   = value[7:0];
                cfg_dir_code = value[7:0];
            end
            msp_pkg::REG_GAIN: begin
                wdata[3:0] = value[3:0];
                cfg_gain   = value[3:0];
            end
            msp_pkg::REG_SOFT_HEAT: begin
                wdata[9:0]    = value[9:0];
                cfg_soft_heat = value[9:0];
            end
            msp_pkg::REG_HARD_HEAT: begin
                wdata[9:0]    = value[9:0];
                cfg_hard_heat = value[9:0];
            end
            msp_pkg::REG_SOFT_DUTY: begin
                wdata[9:0]    = value[9:0];
                cfg_soft_duty = value[9:0];
            end
            msp_pkg::REG_HARD_DUTY: begin
                wdata[9:0]    = value[9:0];
                cfg_hard_duty = value[9:0];
            end
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        pwdata  <= $urandom();
    endtask

    task automatic load_config(int sp, int dir, int gn, int soft_h, int hard_h,
                               int soft_d, int hard_d);
        wait_results_done();
        write_reg(msp_pkg::REG_SETPOINT, sp);
        write_reg(msp_pkg::REG_DIR_CODE, dir);
        write_reg(msp_pkg::REG_GAIN, gn);
        write_reg(msp_pkg::REG_SOFT_HEAT, soft_h);
        write_reg(msp_pkg::REG_HARD_HEAT, hard_h);
        write_reg(msp_pkg::REG_SOFT_DUTY, soft_d);
        write_reg(msp_pkg::REG_HARD_DUTY, hard_d);
    endtask

    // Reset values: stop setpoint keeps the duty at zero, direction left
    task automatic test_stop_setpoint();
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        enc_level = 1'b0;
    endtask

    // Proportional steps up and down, clamp at zero, right direction
    task automatic test_regulation();
        load_config(2, msp_pkg::DIR_RIGHT_CODE, 15, 1000, 1000, 0, 0);
        send_run(1, 0);
        send_run(5, 100);
        send_run(4, 0);
        send_run(1, 100);
        send_run(2, 0);
    endtask

    // Zero gain: the duty only holds
    task automatic test_gain_zero();
        load_config(0, 127, 0, 1000, 1000, 0, 0);
        send_run(3, 0);
        send_run(1, 0);
        send_run(6, 0);
    endtask

    // Cross both heat thresholds; forced duty becomes the accumulator
    task automatic test_heat_limits();
        load_config(0, 129, 1, 3, 6, 1023, 0);
        repeat (8) send_run(1, 100);
        repeat (4) send_run(2, 0);
        repeat (6) send_run(3, 0);
        load_config(5, 0, 15, 1, 1, 300, 1023);
        repeat (3) send_run(1, 100);
        repeat (4) send_run(7, 0);
    endtask

    // A write to the unused address must change nothing
    task automatic test_unused_register();
        load_config(4, msp_pkg::DIR_RIGHT_CODE, 3, 1000, 1000, 0, 0);
        write_reg(REG_UNUSED, 0);
        send_run(2, 0);
        send_run(9, 0);
        send_run(4, 0);
    endtask

    // Counter saturation with no edge, then an edge on the tick after it
    task automatic test_period_saturation();
        load_config(254, 0, 1, 1000, 1000, 0, 0);
        send_run(int'(msp_pkg::PERIOD_MAX) + 1, 50);
        send_run(3, 50);
    endtask

    // Long output stall with the input pushing, then a full drain pause
    task automatic test_backpressure();
        load_config(3, msp_pkg::DIR_RIGHT_CODE, 7, 1000, 1000, 0, 0);
        allow_gaps    = 1'b0;
        stall_request = 80;
        repeat (30) send_run(1, 50);
        allow_gaps = 1'b1;
        wait_results_done();
        repeat (20) send_run($urandom_range(1, 6), 50);
    endtask

    // Random phases of configuration and encoder runs near the setpoint
    task automatic test_random();
        int start_ticks;
        int phase;
        int phase_end;
        int sp;
        int oc_pct;
        int len;
        int r;
        start_ticks = ticks_sent;
        phase       = 0;
        while (ticks_sent - start_ticks < RANDOM_TICKS) begin
            case (phase)
                0: load_config(0, msp_pkg::DIR_RIGHT_CODE, 15, 1, 1000, 1023, 0);
                default: begin
                    load_config(($urandom_range(0, 99) < 75) ? $urandom_range(0, 30)
                                                             : $urandom_range(0, 255),
                                ($urandom_range(0, 1) == 1) ? msp_pkg::DIR_RIGHT_CODE
                                                            : $urandom_range(0, 255),
                                $urandom_range(0, 15),
                                ($urandom_range(0, 1) == 1) ? $urandom_range(1, 40)
                                                            : $urandom_range(1, 1000),
                                ($urandom_range(0, 1) == 1) ? $urandom_range(1, 40)
                                                            : $urandom_range(1, 1000),
                                $urandom_range(0, 1023),
                                $urandom_range(0, 1023));
                end
            endcase
            sp = int'(cfg_setpoint);
            case ($urandom_range(0, 3))
                0: oc_pct = 10;
                1: oc_pct = 50;
                2: oc_pct = 75;
                default: oc_pct = 95;
            endcase
            // One phase runs with no idling on either side
            allow_gaps = (phase != 0);
            phase_end  = ticks_sent + 150;
            while (ticks_sent < phase_end) begin
                r = $urandom_range(0, 99);
                if (r < 65) begin
                    len = sp + $urandom_range(0, 6) - 3;
                    if (len < 1) len = 1;
                    if (len > 300) len = 300;
                end else if (r < 85) begin
                    len = $urandom_range(1, 8);
                end else begin
                    len = $urandom_range(1, 300);
                end
                send_run(len, oc_pct);
            end
            allow_gaps = 1'b1;
            phase++;
        end
    endtask

    initial begin
        tick_count    = 0;
        last_level    = 1'b0;
        duty_acc      = 0;
        heat          = 0;
        cfg_setpoint  = msp_pkg::RST_SETPOINT;
        cfg_dir_code  = msp_pkg::RST_DIR_CODE;
        cfg_gain      = msp_pkg::RST_GAIN;
        cfg_soft_heat = msp_pkg::RST_SOFT_HEAT;
        cfg_hard_heat = msp_pkg::RST_HARD_HEAT;
        cfg_soft_duty = msp_pkg::RST_SOFT_DUTY;
        cfg_hard_duty = msp_pkg::RST_HARD_DUTY;
        fail_count    = 0;
        ticks_sent    = 0;
        enc_level     = 1'b0;
        allow_gaps    = 1'b1;
        stall_request = 0;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_data        = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_stop_setpoint();
        test_regulation();
        test_gain_zero();
        test_heat_limits();
        test_unused_register();
        test_period_saturation();
        test_backpressure();
        test_random();

        // Drain the outstanding updates, bounded
        @(negedge i_clk);
        i_valid <= 1'b0;
        for (int n = 0; n < 20000 && pending_updates.size() != 0; n++) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (pending_updates.size() != 0) begin
            $display("%0t: %0d updates never arrived, expected 0 pending, got %0d",
                     $time, pending_updates.size(), pending_updates.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

    // Hard stop in case the handshake hangs
    initial begin
        #2_000_000;
        $display("tb_top failed");
        $finish;
    end

endmodule
